// ----- rtl/drtt_pkg.sv -----
// Shared constants and types of the delayed report timer table.
package drtt_pkg;

  localparam int SLOTS      = 8;
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_OUT_W = 3;
  localparam int EP_W       = 8;
  localparam int ID_W       = 16;
  localparam int DLY_W      = 32;

  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_TICK     = 1'b1;
  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_FIRE   = 1'b1;

  // One write to a table entry; the key and the delay can be written separately.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             set_key;
    logic [EP_W-1:0]  endpoint;
    logic [ID_W-1:0]  cluster;
    logic [ID_W-1:0]  attribute;
    logic             set_rem;
    logic [DLY_W-1:0] remaining;
    logic             set_valid;
    logic             clr_valid;
  } tbl_wr_t;

  // Contents of the entry under the walk index.
  typedef struct packed {
    logic             valid;
    logic [EP_W-1:0]  endpoint;
    logic [ID_W-1:0]  cluster;
    logic [ID_W-1:0]  attribute;
    logic [DLY_W-1:0] remaining;
  } tbl_rd_t;

  // Results of the shared compare unit for one entry.
  typedef struct packed {
    logic             key_eq;
    logic             due;
    logic [DLY_W-1:0] rem_dec;
  } unit_res_t;

endpackage

// ----- rtl/delayed_report_timer_table.sv -----
// Top level of the delayed report timer table: request capture, slot walker and result register.
//
// Each request is handled by walking the slots one per cycle through a single shared compare
// unit, and no new request is taken during the walk; a tick walk pauses while a due entry waits
// for the output register. A schedule request is accepted, walks every slot, then does the write
// and acknowledgement; a schedule with endpoint 0 skips the walk. A tick walks every slot, during
// which each due entry is freed and its report queued, then hands over the last queued report.
// The walk, the acknowledgement and the flush wait only while the result register is held by a
// stalled receiver. Results leave through a registered output, so the next request is taken even
// while the final result is still waiting to be collected. Slot storage needs no clearing pass:
// valid bits are cleared by reset.
module delayed_report_timer_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        op,
  input  logic [7:0]  endpoint,
  input  logic [15:0] cluster_id,
  input  logic [15:0] attribute_id,
  input  logic [31:0] delay,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        kind,
  output logic        accepted,
  output logic [2:0]  slot,
  output logic [7:0]  out_endpoint,
  output logic [15:0] out_cluster,
  output logic [15:0] out_attribute,
  output logic        last
);
  import drtt_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    SCAN_SCHED,
    ACK,
    SCAN_TICK,
    FLUSH
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] idx;
  logic [EP_W-1:0]  r_ep;
  logic [ID_W-1:0]  r_cl;
  logic [ID_W-1:0]  r_at;
  logic [DLY_W-1:0] r_dly;
  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             pend_valid;
  logic [IDX_W-1:0] pend_idx;
  logic [EP_W-1:0]  pend_ep;
  logic [ID_W-1:0]  pend_cl;
  logic [ID_W-1:0]  pend_at;

  tbl_rd_t   entry;
  tbl_wr_t   wr;
  logic      wr_en;
  unit_res_t res;
  logic      out_free;
  logic      idx_end;
  logic      tick_hold;
  logic      rsp_load;

  drtt_table u_table (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (idx),
    .rd     (entry),
    .wr_en  (wr_en),
    .wr     (wr)
  );

  drtt_unit u_unit (
    .endpoint  (r_ep),
    .cluster   (r_cl),
    .attribute (r_at),
    .entry     (entry),
    .res       (res)
  );

  function automatic logic [SLOT_OUT_W-1:0] to_slot(input logic [IDX_W-1:0] i);
    logic [IDX_W+SLOT_OUT_W-1:0] ext;
    ext = {{SLOT_OUT_W{1'b0}}, i};
    return ext[SLOT_OUT_W-1:0];
  endfunction

  assign out_free  = !rsp_valid || !rsp_stall;
  assign idx_end   = (idx == IDX_W'(SLOTS - 1));
  assign req_stall = (state != IDLE);
  // A due entry cannot be taken while an earlier report still waits for the output register.
  assign tick_hold = entry.valid && res.due && pend_valid && !out_free;

  // The result register is loaded in this cycle.
  always_comb begin
    case (state)
      ACK: begin
        rsp_load = out_free;
      end
      SCAN_TICK: begin
        rsp_load = !tick_hold && entry.valid && res.due && pend_valid;
      end
      FLUSH: begin
        rsp_load = pend_valid && out_free;
      end
      default: begin
        rsp_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr           = '0;
    wr_en        = 1'b0;
    wr.idx       = idx;
    wr.endpoint  = r_ep;
    wr.cluster   = r_cl;
    wr.attribute = r_at;
    wr.remaining = res.rem_dec;
    case (state)
      ACK: begin
        if (out_free && (hit_found || free_found)) begin
          wr_en        = 1'b1;
          wr.idx       = hit_found ? hit_idx : free_idx;
          wr.set_key   = !hit_found;
          wr.set_valid = !hit_found;
          wr.set_rem   = 1'b1;
          wr.remaining = r_dly;
        end
      end
      SCAN_TICK: begin
        if (entry.valid && !tick_hold) begin
          wr_en = 1'b1;
          if (res.due) begin
            wr.clr_valid = 1'b1;
          end else begin
            wr.set_rem = 1'b1;
          end
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      rsp_valid  <= 1'b0;
      pend_valid <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      idx        <= '0;
    end else begin
      if (rsp_valid && !rsp_stall && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req_valid) begin
            r_ep       <= endpoint;
            r_cl       <= cluster_id;
            r_at       <= attribute_id;
            r_dly      <= delay;
            idx        <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            pend_valid <= 1'b0;
            if (op == OP_TICK) begin
              state <= SCAN_TICK;
            end else if (endpoint == '0) begin
              state <= ACK;
            end else begin
              state <= SCAN_SCHED;
            end
          end
        end
        SCAN_SCHED: begin
          if (entry.valid) begin
            if (!hit_found && res.key_eq) begin
              hit_found <= 1'b1;
              hit_idx   <= idx;
            end
          end else if (!free_found) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
          if (idx_end) begin
            state <= ACK;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        ACK: begin
          if (out_free) begin
            rsp_valid     <= 1'b1;
            kind          <= KIND_ACK;
            accepted      <= hit_found || free_found;
            slot          <= hit_found ? to_slot(hit_idx) :
                             (free_found ? to_slot(free_idx) : '0);
            out_endpoint  <= '0;
            out_cluster   <= '0;
            out_attribute <= '0;
            last          <= 1'b1;
            state         <= IDLE;
          end
        end
        SCAN_TICK: begin
          if (!tick_hold) begin
            if (entry.valid && res.due) begin
              if (pend_valid) begin
                rsp_valid     <= 1'b1;
                kind          <= KIND_FIRE;
                accepted      <= 1'b0;
                slot          <= to_slot(pend_idx);
                out_endpoint  <= pend_ep;
                out_cluster   <= pend_cl;
                out_attribute <= pend_at;
                last          <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_idx   <= idx;
              pend_ep    <= entry.endpoint;
              pend_cl    <= entry.cluster;
              pend_at    <= entry.attribute;
            end
            if (idx_end) begin
              state <= FLUSH;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        FLUSH: begin
          if (!pend_valid) begin
            state <= IDLE;
          end else if (out_free) begin
            rsp_valid     <= 1'b1;
            kind          <= KIND_FIRE;
            accepted      <= 1'b0;
            slot          <= to_slot(pend_idx);
            out_endpoint  <= pend_ep;
            out_cluster   <= pend_cl;
            out_attribute <= pend_at;
            last          <= 1'b1;
            pend_valid    <= 1'b0;
            state         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/drtt_table.sv -----
// Slot storage: keys and remaining delays per slot, with valid bits cleared by reset.
module drtt_table (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [drtt_pkg::IDX_W-1:0] rd_idx,
  output drtt_pkg::tbl_rd_t       rd,
  input  logic                    wr_en,
  input  drtt_pkg::tbl_wr_t       wr
);
  import drtt_pkg::*;

  logic [SLOTS-1:0] valid;
  logic [EP_W-1:0]  ep_mem  [SLOTS];
  logic [ID_W-1:0]  cl_mem  [SLOTS];
  logic [ID_W-1:0]  at_mem  [SLOTS];
  logic [DLY_W-1:0] rem_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      if (wr.set_valid) begin
        valid[wr.idx] <= 1'b1;
      end else if (wr.clr_valid) begin
        valid[wr.idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr.set_key) begin
      ep_mem[wr.idx] <= wr.endpoint;
      cl_mem[wr.idx] <= wr.cluster;
      at_mem[wr.idx] <= wr.attribute;
    end
    if (wr_en && wr.set_rem) begin
      rem_mem[wr.idx] <= wr.remaining;
    end
  end

  always_comb begin
    rd.valid     = valid[rd_idx];
    rd.endpoint  = ep_mem[rd_idx];
    rd.cluster   = cl_mem[rd_idx];
    rd.attribute = at_mem[rd_idx];
    rd.remaining = rem_mem[rd_idx];
  end

endmodule

// ----- rtl/drtt_unit.sv -----
// Shared compare unit: key match, due test and countdown for one entry.
module drtt_unit (
  input  logic [drtt_pkg::EP_W-1:0] endpoint,
  input  logic [drtt_pkg::ID_W-1:0] cluster,
  input  logic [drtt_pkg::ID_W-1:0] attribute,
  input  drtt_pkg::tbl_rd_t         entry,
  output drtt_pkg::unit_res_t       res
);
  import drtt_pkg::*;

  always_comb begin
    res.key_eq  = (entry.endpoint == endpoint) && (entry.cluster == cluster) &&
                  (entry.attribute == attribute);
    // A delay of zero or one is due on this tick.
    res.due     = (entry.remaining[DLY_W-1:1] == '0);
    res.rem_dec = entry.remaining - DLY_W'(1);
  end

endmodule

// ----- rtl/drtt_checker.sv -----
// Port-level checks of the delayed report timer table, bound to the top level.
module drtt_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic        kind,
  input logic        accepted,
  input logic [2:0]  slot,
  input logic [7:0]  out_endpoint,
  input logic        last
);
  import drtt_pkg::*;

  // A result held by the receiver stays valid and keeps its slot, kind and last flag.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(slot) && $stable(kind) && $stable(last))
    else $error("stalled result changed");

  // Every accepted request keeps the block busy for at least the next cycle.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while the walk should be running");

  // An acknowledgement is always the only result of its request and carries no report.
  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (kind == KIND_ACK) |-> last && (out_endpoint == '0))
    else $error("acknowledgement not marked last or carries a report");

  // Fired reports never claim acceptance, and a rejection names slot zero.
  a_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((kind == KIND_FIRE) && !accepted) ||
                  ((kind == KIND_ACK) && (accepted || (slot == '0))))
    else $error("inconsistent result fields");

endmodule

bind delayed_report_timer_table drtt_checker u_drtt_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req_valid),
  .req_stall    (req_stall),
  .rsp_valid    (rsp_valid),
  .rsp_stall    (rsp_stall),
  .kind         (kind),
  .accepted     (accepted),
  .slot         (slot),
  .out_endpoint (out_endpoint),
  .last         (last)
);

// ----- bench/delayed_report_timer_table_test.sv -----
// Self-checking testbench for the delayed report timer table, with its own model of the slots.
module delayed_report_timer_table_test;
  import drtt_pkg::*;

  typedef struct packed {
    logic                  kind;
    logic                  accepted;
    logic [SLOT_OUT_W-1:0] slot;
    logic [EP_W-1:0]       endpoint;
    logic [ID_W-1:0]       cluster;
    logic [ID_W-1:0]       attribute;
    logic                  last;
  } report_row_t;

  // Mirrors the slot table and keeps the acknowledgements and reports still to come.
  class report_tracker;
    bit               live [SLOTS];
    logic [EP_W-1:0]  ep_tab [SLOTS];
    logic [ID_W-1:0]  cl_tab [SLOTS];
    logic [ID_W-1:0]  at_tab [SLOTS];
    logic [DLY_W-1:0] rem_tab [SLOTS];
    report_row_t      awaited [$];
    int               errors;

    function new();
      foreach (live[i]) live[i] = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 100) $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_field(input string name, input int got, input int want);
      if (got != want) report($sformatf("%s is 0x%0h, 0x%0h expected", name, got, want));
    endtask

    // Works out the results of one accepted request and updates the mirrored table.
    task take_request(input logic op_in, input logic [EP_W-1:0] ep, input logic [ID_W-1:0] cl,
                      input logic [ID_W-1:0] at, input logic [DLY_W-1:0] dly);
      int          hit;
      int          free_idx;
      int          fired;
      report_row_t row;
      hit = -1;
      free_idx = -1;
      fired = 0;
      if (op_in == OP_SCHEDULE) begin
        if (ep != '0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (live[i]) begin
              if (hit < 0 && ep_tab[i] == ep && cl_tab[i] == cl && at_tab[i] == at) hit = i;
            end else if (free_idx < 0) begin
              free_idx = i;
            end
          end
          if (hit < 0 && free_idx >= 0) begin
            hit = free_idx;
            live[hit] = 1'b1;
            ep_tab[hit] = ep;
            cl_tab[hit] = cl;
            at_tab[hit] = at;
          end
          if (hit >= 0) rem_tab[hit] = dly;
        end
        row = '0;
        row.kind = KIND_ACK;
        row.last = 1'b1;
        if (hit >= 0) begin
          row.accepted = 1'b1;
          row.slot = SLOT_OUT_W'(hit);
        end
        awaited.push_back(row);
      end else begin
        // A delay of 0 counts as due, just as 1 does.
        for (int i = 0; i < SLOTS; i++) begin
          if (!live[i]) continue;
          if (rem_tab[i] <= 1) begin
            row = '0;
            row.kind = KIND_FIRE;
            row.slot = SLOT_OUT_W'(i);
            row.endpoint = ep_tab[i];
            row.cluster = cl_tab[i];
            row.attribute = at_tab[i];
            awaited.push_back(row);
            live[i] = 1'b0;
            fired++;
          end else begin
            rem_tab[i] = rem_tab[i] - 1;
          end
        end
        if (fired > 0) begin
          row = awaited.pop_back();
          row.last = 1'b1;
          awaited.push_back(row);
        end
      end
    endtask

    task match_result(input report_row_t got);
      report_row_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result 0x%0h arrived with nothing outstanding", got));
        return;
      end
      want = awaited.pop_front();
      check_field("kind", got.kind, want.kind);
      check_field("accepted", got.accepted, want.accepted);
      check_field("slot", got.slot, want.slot);
      check_field("out_endpoint", got.endpoint, want.endpoint);
      check_field("out_cluster", got.cluster, want.cluster);
      check_field("out_attribute", got.attribute, want.attribute);
      check_field("last", got.last, want.last);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic                  op = OP_SCHEDULE;
  logic [EP_W-1:0]       endpoint = '0;
  logic [ID_W-1:0]       cluster_id = '0;
  logic [ID_W-1:0]       attribute_id = '0;
  logic [DLY_W-1:0]      delay = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic                  kind;
  logic                  accepted;
  logic [SLOT_OUT_W-1:0] slot;
  logic [EP_W-1:0]       out_endpoint;
  logic [ID_W-1:0]       out_cluster;
  logic [ID_W-1:0]       out_attribute;
  logic                  last;

  report_tracker tracker = new();

  // Small pool of keys, so that restarts and near misses on the key are frequent.
  localparam int KEYS = 6;
  logic [EP_W-1:0] key_ep [KEYS];
  logic [ID_W-1:0] key_cl [KEYS];
  logic [ID_W-1:0] key_at [KEYS];

  int burst_left = 0;
  int stall_mode = 0;
  int stall_run = 0;

  delayed_report_timer_table u_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  // The receiver switches between free running, light, even and heavy stalling.
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run = $urandom_range(5, 40);
    end
    stall_run--;
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      2: rsp_stall <= ($urandom_range(0, 1) == 0);
      default: rsp_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin : collect
    report_row_t got;
    if (!rst && rsp_valid && !rsp_stall) begin
      got.kind = kind;
      got.accepted = accepted;
      got.slot = slot;
      got.endpoint = out_endpoint;
      got.cluster = out_cluster;
      got.attribute = out_attribute;
      got.last = last;
      tracker.match_result(got);
    end
  end

  // Holds the request until it is taken; valid is left high for a following request.
  task send_request(input logic o, input logic [EP_W-1:0] ep, input logic [ID_W-1:0] cl,
                    input logic [ID_W-1:0] at, input logic [DLY_W-1:0] dly);
    req_valid <= 1'b1;
    op <= o;
    endpoint <= ep;
    cluster_id <= cl;
    attribute_id <= at;
    delay <= dly;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    tracker.take_request(o, ep, cl, at, dly);
  endtask

  task send_tick();
    send_request(OP_TICK, EP_W'($urandom), ID_W'($urandom), ID_W'($urandom), $urandom);
  endtask

  task drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task send_random_schedule();
    int pick;
    int k;
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, KEYS - 1);
    if (pick < 6) begin
      send_request(OP_SCHEDULE, '0, ID_W'($urandom), ID_W'($urandom), $urandom);
    end else if (pick < 18) begin
      send_request(OP_SCHEDULE, EP_W'($urandom_range(1, 255)), ID_W'($urandom),
                   ID_W'($urandom), $urandom_range(0, 4));
    end else if (pick < 26) begin
      // Long delays only go to pooled keys, so a later restart can bring them due.
      send_request(OP_SCHEDULE, key_ep[k], key_cl[k], key_at[k], $urandom);
    end else begin
      send_request(OP_SCHEDULE, key_ep[k], key_cl[k], key_at[k], $urandom_range(0, 6));
    end
  endtask

  initial begin
    for (int i = 0; i < KEYS; i++) begin
      key_ep[i] = EP_W'($urandom_range(1, 255));
      key_cl[i] = ID_W'($urandom);
      key_at[i] = ID_W'($urandom);
    end
    // Keys that differ from another key in a single field only: keys 1 and 2 from key 0, key 3 from key 4.
    key_ep[1] = key_ep[0];
    key_cl[1] = key_cl[0];
    key_ep[2] = key_ep[0];
    key_at[2] = key_at[0];
    key_cl[3] = key_cl[4];
    key_at[3] = key_at[4];

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty tick, rejects, extremes, restarts, a full table and a full firing.
    send_tick();
    send_request(OP_SCHEDULE, '0, 16'h1234, 16'h5678, 32'd3);
    send_request(OP_SCHEDULE, 8'hff, 16'hffff, 16'hffff, 32'hffffffff);
    send_request(OP_SCHEDULE, 8'h01, 16'h0000, 16'h0000, 32'd0);
    send_request(OP_SCHEDULE, 8'h01, 16'h0000, 16'h0000, 32'd2);
    for (int i = 2; i < SLOTS; i++)
      send_request(OP_SCHEDULE, EP_W'(i), ID_W'(i), ID_W'(16'h8000 >> i), 32'd1);
    send_request(OP_SCHEDULE, 8'h80, 16'h00ff, 16'hff00, 32'd1);
    send_request(OP_SCHEDULE, 8'h01, 16'h0000, 16'h0000, 32'd2);
    send_tick();
    send_tick();
    send_request(OP_SCHEDULE, 8'hff, 16'hffff, 16'hffff, 32'd1);
    for (int i = 1; i < SLOTS; i++)
      send_request(OP_SCHEDULE, EP_W'(8'h40 + i), ID_W'(16'h0f0f ^ i), ID_W'(16'hf0f0 + i),
                   DLY_W'(i % 2));
    send_tick();
    drain_results();

    for (int n = 0; n < 100; n++) begin
      pace_sender();
      if (n == 40 || n == 80) drain_results();
      if ($urandom_range(0, 99) < 40) send_tick();
      else send_random_schedule();
    end

    // Flush out whatever is still due so the table ends empty of short delays.
    repeat (8) send_tick();
    drain_results();
    repeat (40) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
